[rtl/thkr_pkg.sv]
package thkr_pkg;

	// Key group codes on the key_class field
	localparam logic [1:0] CLS_OTHER = 2'd0;
	localparam logic [1:0] CLS_MOD   = 2'd1;
	localparam logic [1:0] CLS_PREF  = 2'd2;

	// Action codes of a result beat
	localparam logic [2:0] ACT_TAP          = 3'd0;
	localparam logic [2:0] ACT_HOLD_TAP     = 3'd1;
	localparam logic [2:0] ACT_HOLD_PRESS   = 3'd2;
	localparam logic [2:0] ACT_HOLD_RELEASE = 3'd3;
	localparam logic [2:0] ACT_MOD_PRESS    = 3'd4;
	localparam logic [2:0] ACT_MOD_RELEASE  = 3'd5;
	localparam logic [2:0] ACT_END          = 3'd6;

	// Configuration register indexes
	localparam logic CFG_TAPPING_TERM = 1'b0;
	localparam logic CFG_HOLD_MASK    = 1'b1;

	localparam int CFG_W        = 16;
	localparam int TIME_W       = 16;
	localparam int IDX_W        = 4;
	localparam int MASK_W       = 11;
	localparam logic [TIME_W-1:0] TERM_RESET = 16'd200;
	localparam logic [MASK_W-1:0] MASK_RESET = 11'd2040;

	localparam int MOD_KEYS_DEF  = 7;
	localparam int PREF_KEYS_DEF = 11;

endpackage

[rtl/tap_hold_key_resolver.sv]
// Channel   Handshake              Payload
// evt       evt_valid / evt_stall  mode, key_class, key_index, pressed, now_ms
// res       res_valid / res_stall  action, key_index_res, pass_through, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is taken, then a small sequencer visits the keys one at a time, walking the groups
// through a single elapsed-time subtract and compare, then handles the key's own press or
// release on a key event, and closes with the end beat. No new item is taken before the
// sequencer is back in idle. A scan visits both groups. A press of an other or tap-preferred
// key visits both groups, a modifier-tap press visits only the tap-preferred group, and a
// release visits neither. A beat that finds the result register still stalled holds the
// sequencer for as long as that stall lasts. Reset (arst_n low) clears the down, hold and
// tapped bits of every key, the sequencer and the result register, and loads the register
// defaults; the press times are not reset. No clearing pass follows reset.
module tap_hold_key_resolver #(
	parameter int MOD_KEYS  = thkr_pkg::MOD_KEYS_DEF,
	parameter int PREF_KEYS = thkr_pkg::PREF_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// event / scan channel
	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  logic                          mode,
	input  logic [1:0]                    key_class,
	input  logic [thkr_pkg::IDX_W-1:0]    key_index,
	input  logic                          pressed,
	input  logic [thkr_pkg::TIME_W-1:0]   now_ms,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [2:0]                    action,
	output logic [thkr_pkg::IDX_W-1:0]    key_index_res,
	output logic                          pass_through,
	output logic                          last,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [thkr_pkg::CFG_W-1:0]    cfg_data
);

	localparam int MAX_KEYS   = (MOD_KEYS > PREF_KEYS) ? MOD_KEYS : PREF_KEYS;
	localparam int CNT_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int MOD_SEL_W  = (MOD_KEYS > 1) ? $clog2(MOD_KEYS) : 1;
	localparam int PREF_SEL_W = (PREF_KEYS > 1) ? $clog2(PREF_KEYS) : 1;
	localparam int IDXX_W     = thkr_pkg::IDX_W + 1;
	localparam int MASKX_W    = 1 << thkr_pkg::IDX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_PREF,
		S_OWN,
		S_END
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	// latched item
	logic                          mode_q;
	logic [1:0]                    cls_q;
	logic [thkr_pkg::IDX_W-1:0]    idx_q;
	logic                          press_q;
	logic [thkr_pkg::TIME_W-1:0]   now_q;
	logic                          pt_q;

	// configuration
	logic [thkr_pkg::TIME_W-1:0]   tapping_term_q;
	logic [thkr_pkg::MASK_W-1:0]   hold_mask_q;

	// key state
	logic [thkr_pkg::TIME_W-1:0]   mod_start_q  [MOD_KEYS];
	logic [thkr_pkg::TIME_W-1:0]   pref_start_q [PREF_KEYS];
	logic [MOD_KEYS-1:0]           mod_down_q, mod_hold_q;
	logic [PREF_KEYS-1:0]          pref_down_q, pref_hold_q, pref_tapped_q;

	// result register
	logic                          res_valid_q;
	logic [2:0]                    action_q;
	logic [thkr_pkg::IDX_W-1:0]    key_res_q;
	logic                          pt_res_q;
	logic                          last_q;

	// sequencer datapath
	logic [1:0]                    cls_n;
	logic [MOD_SEL_W-1:0]          mod_sel, own_mod_sel;
	logic [PREF_SEL_W-1:0]         pref_sel, own_pref_sel;
	logic [thkr_pkg::IDX_W-1:0]    cnt_idx;
	logic [thkr_pkg::TIME_W-1:0]   start_sel, elapsed;
	logic                          past_term;
	logic [MASKX_W-1:0]            mask_ext;
	logic                          mod_hit, pref_hit, mod_end, pref_end;
	logic                          out_free;
	logic                          own_emit;
	logic [2:0]                    own_act;
	logic                          start_we;
	logic                          res_load;

	assign evt_stall     = (state_q != S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE);
	assign res_valid     = res_valid_q;
	assign action        = action_q;
	assign key_index_res = key_res_q;
	assign pass_through  = pt_res_q;
	assign last          = last_q;

	always_comb begin
		// fold out-of-range indexes and class three into the other class
		cls_n = key_class;
		if (key_class == thkr_pkg::CLS_MOD
		    && {1'b0, key_index} >= IDXX_W'(MOD_KEYS)) begin
			cls_n = thkr_pkg::CLS_OTHER;
		end
		if (key_class == thkr_pkg::CLS_PREF
		    && {1'b0, key_index} >= IDXX_W'(PREF_KEYS)) begin
			cls_n = thkr_pkg::CLS_OTHER;
		end
		if (key_class != thkr_pkg::CLS_MOD && key_class != thkr_pkg::CLS_PREF) begin
			cls_n = thkr_pkg::CLS_OTHER;
		end
	end

	always_comb begin
		mod_sel      = cnt_q[MOD_SEL_W-1:0];
		pref_sel     = cnt_q[PREF_SEL_W-1:0];
		own_mod_sel  = idx_q[MOD_SEL_W-1:0];
		own_pref_sel = idx_q[PREF_SEL_W-1:0];
		cnt_idx      = thkr_pkg::IDX_W'(cnt_q);
		mask_ext     = MASKX_W'(hold_mask_q);

		// shared unit: elapsed time of the visited key against the term
		start_sel = (state_q == S_MOD) ? mod_start_q[mod_sel] : pref_start_q[pref_sel];
		elapsed   = now_q - start_sel;
		past_term = elapsed > tapping_term_q;

		mod_hit  = mod_down_q[mod_sel] && !mod_hold_q[mod_sel]
		           && (!mode_q || past_term);
		pref_hit = pref_down_q[pref_sel] && !pref_hold_q[pref_sel]
		           && !pref_tapped_q[pref_sel]
		           && (mode_q ? past_term
		                      : !(cls_q == thkr_pkg::CLS_PREF && idx_q == cnt_idx));
		mod_end  = (cnt_q == CNT_W'(MOD_KEYS - 1));
		pref_end = (cnt_q == CNT_W'(PREF_KEYS - 1));

		out_free = !res_valid_q || !res_stall;

		// the key's own release record
		own_emit = 1'b0;
		own_act  = thkr_pkg::ACT_TAP;
		if (!press_q && cls_q == thkr_pkg::CLS_MOD) begin
			own_emit = 1'b1;
			own_act  = mod_hold_q[own_mod_sel] ? thkr_pkg::ACT_MOD_RELEASE
			                                   : thkr_pkg::ACT_TAP;
		end
		if (!press_q && cls_q == thkr_pkg::CLS_PREF) begin
			if (pref_hold_q[own_pref_sel]) begin
				own_emit = mask_ext[idx_q];
				own_act  = thkr_pkg::ACT_HOLD_RELEASE;
			end else begin
				own_emit = !pref_tapped_q[own_pref_sel];
				own_act  = thkr_pkg::ACT_TAP;
			end
		end

		start_we = (state_q == S_OWN) && press_q && (!own_emit || out_free);

		// a new result beat enters the register this cycle
		res_load = out_free && ((state_q == S_MOD && mod_hit)
		                        || (state_q == S_PREF && pref_hit)
		                        || (state_q == S_OWN && own_emit)
		                        || state_q == S_END);
	end

	// press times: written on the key's own press, no reset needed since a start is
	// only read while its down bit is set
	always_ff @(posedge clk) begin
		if (start_we && cls_q == thkr_pkg::CLS_MOD) begin
			mod_start_q[own_mod_sel] <= now_q;
		end
		if (start_we && cls_q == thkr_pkg::CLS_PREF) begin
			pref_start_q[own_pref_sel] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tapping_term_q <= thkr_pkg::TERM_RESET;
			hold_mask_q    <= thkr_pkg::MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				thkr_pkg::CFG_TAPPING_TERM: tapping_term_q <= cfg_data;
				thkr_pkg::CFG_HOLD_MASK:    hold_mask_q <= cfg_data[thkr_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			mod_down_q    <= '0;
			mod_hold_q    <= '0;
			pref_down_q   <= '0;
			pref_hold_q   <= '0;
			pref_tapped_q <= '0;
			res_valid_q   <= 1'b0;
			action_q      <= thkr_pkg::ACT_END;
			key_res_q     <= '0;
			pt_res_q      <= 1'b0;
			last_q        <= 1'b0;
			mode_q        <= 1'b0;
			cls_q         <= thkr_pkg::CLS_OTHER;
			idx_q         <= '0;
			press_q       <= 1'b0;
			now_q         <= '0;
			pt_q          <= 1'b0;
		end else begin
			// load a new result beat, or drop the old one once the far side takes it
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						mode_q  <= mode;
						cls_q   <= cls_n;
						idx_q   <= key_index;
						press_q <= pressed;
						now_q   <= now_ms;
						pt_q    <= !mode && cls_n == thkr_pkg::CLS_OTHER;
						cnt_q   <= '0;
						if (mode) begin
							state_q <= S_MOD;
						end else if (pressed) begin
							state_q <= S_PREF;
						end else begin
							state_q <= S_OWN;
						end
					end
				end

				// visit one modifier-tap key; hold here while a record cannot leave
				S_MOD: begin
					if (!mod_hit || out_free) begin
						if (mod_hit) begin
							action_q            <= thkr_pkg::ACT_MOD_PRESS;
							key_res_q           <= cnt_idx;
							pt_res_q            <= 1'b0;
							last_q              <= 1'b0;
							mod_hold_q[mod_sel] <= 1'b1;
						end
						if (mod_end) begin
							cnt_q   <= '0;
							state_q <= mode_q ? S_PREF : S_OWN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end

				// visit one tap-preferred key
				S_PREF: begin
					if (!pref_hit || out_free) begin
						if (pref_hit) begin
							key_res_q   <= cnt_idx;
							pt_res_q    <= 1'b0;
							last_q      <= 1'b0;
							if (mode_q) begin
								action_q <= mask_ext[cnt_idx] ? thkr_pkg::ACT_HOLD_PRESS
								                              : thkr_pkg::ACT_HOLD_TAP;
								pref_hold_q[pref_sel] <= 1'b1;
							end else begin
								action_q                <= thkr_pkg::ACT_TAP;
								pref_tapped_q[pref_sel] <= 1'b1;
							end
						end
						if (pref_end) begin
							cnt_q <= '0;
							if (mode_q) begin
								state_q <= S_END;
							end else if (cls_q != thkr_pkg::CLS_MOD) begin
								state_q <= S_MOD;
							end else begin
								state_q <= S_OWN;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end

				// the key's own press or release
				S_OWN: begin
					if (!own_emit || out_free) begin
						if (own_emit) begin
							action_q    <= own_act;
							key_res_q   <= idx_q;
							pt_res_q    <= 1'b0;
							last_q      <= 1'b0;
						end
						if (cls_q == thkr_pkg::CLS_MOD) begin
							mod_down_q[own_mod_sel] <= press_q;
							mod_hold_q[own_mod_sel] <= 1'b0;
						end
						if (cls_q == thkr_pkg::CLS_PREF) begin
							pref_down_q[own_pref_sel]   <= press_q;
							pref_hold_q[own_pref_sel]   <= 1'b0;
							pref_tapped_q[own_pref_sel] <= 1'b0;
						end
						state_q <= S_END;
					end
				end

				S_END: begin
					if (out_free) begin
						action_q    <= thkr_pkg::ACT_END;
						key_res_q   <= '0;
						pt_res_q    <= pt_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/thkr_check.sv]
module thkr_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        evt_valid,
	input logic                        evt_stall,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [2:0]                  action,
	input logic [thkr_pkg::IDX_W-1:0]  key_index_res,
	input logic                        pass_through,
	input logic                        last
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(action)
		&& $stable(key_index_res) && $stable(pass_through) && $stable(last))
		else $error("stalled result beat changed");

	// an accepted item keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall |=> evt_stall)
		else $error("block took no time for an item");

	// last marks the end record and nothing else
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (last == (action == thkr_pkg::ACT_END)))
		else $error("last and end record disagree");

	// pass-through only on the end record
	a_pt_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pass_through |-> action == thkr_pkg::ACT_END)
		else $error("pass-through on an action record");

	// end record names key zero
	a_end_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action == thkr_pkg::ACT_END |-> key_index_res == '0)
		else $error("end record with a key index");

endmodule

bind tap_hold_key_resolver thkr_check u_thkr_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt_valid),
	.evt_stall     (evt_stall),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.action        (action),
	.key_index_res (key_index_res),
	.pass_through  (pass_through),
	.last          (last)
);

[dv/tb_tap_hold_key_resolver.sv]
`timescale 1ns / 1ps

module tb_tap_hold_key_resolver;

	localparam int NMOD  = thkr_pkg::MOD_KEYS_DEF;
	localparam int NPREF = thkr_pkg::PREF_KEYS_DEF;

	// Item kinds on the mode field, and the unused key class
	localparam logic       MODE_KEY  = 1'b0;
	localparam logic       MODE_SCAN = 1'b1;
	localparam logic [1:0] CLS_SPARE = 2'd3;

	// Bound for the longest item, a press that visits both groups, with no result stall
	localparam int ITEM_CYCLES = NMOD + NPREF + 3;
	// Cycles with no beat on any channel before the run is declared hung
	localparam int HANG_LIMIT  = 2000;

	typedef struct packed {
		logic                        mode;
		logic [1:0]                  key_class;
		logic [thkr_pkg::IDX_W-1:0]  key_index;
		logic                        pressed;
		logic [thkr_pkg::TIME_W-1:0] now_ms;
	} key_item_t;

	typedef struct packed {
		logic [2:0]                 action;
		logic [thkr_pkg::IDX_W-1:0] key_index;
		logic                       pass_through;
		logic                       last;
	} res_beat_t;

	// DUT ports; every input is known from time zero
	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        evt_valid     = 1'b0;
	logic                        evt_stall;
	logic                        mode          = MODE_KEY;
	logic [1:0]                  key_class     = thkr_pkg::CLS_OTHER;
	logic [thkr_pkg::IDX_W-1:0]  key_index     = '0;
	logic                        pressed       = 1'b0;
	logic [thkr_pkg::TIME_W-1:0] now_ms        = '0;
	logic                        res_valid;
	logic                        res_stall     = 1'b0;
	logic [2:0]                  action;
	logic [thkr_pkg::IDX_W-1:0]  key_index_res;
	logic                        pass_through;
	logic                        last;
	logic                        cfg_valid     = 1'b0;
	logic                        cfg_ready;
	logic                        cfg_index     = thkr_pkg::CFG_TAPPING_TERM;
	logic [thkr_pkg::CFG_W-1:0]  cfg_data      = '0;

	// Predicted key state and register copies
	logic [thkr_pkg::TIME_W-1:0] mod_start  [NMOD];
	logic [NMOD-1:0]             mod_down;
	logic [NMOD-1:0]             mod_hold;
	logic [thkr_pkg::TIME_W-1:0] pref_start [NPREF];
	logic [NPREF-1:0]            pref_down;
	logic [NPREF-1:0]            pref_hold;
	logic [NPREF-1:0]            pref_tapped;
	logic [thkr_pkg::TIME_W-1:0] term;
	logic [thkr_pkg::MASK_W-1:0] hold_mask;

	// Result beats still owed by the block, oldest first
	res_beat_t pending_beats[$];

	// Stimulus-side view of which grouped keys the test is holding down
	logic [NMOD-1:0]             mod_phys  = '0;
	logic [NPREF-1:0]            pref_phys = '0;
	logic [thkr_pkg::TIME_W-1:0] ms_clock  = '0;

	int evt_idle_pct   = 0;
	int res_stall_pct  = 0;
	int hold_off_left  = 0;
	int errors         = 0;
	int items_sent     = 0;
	int beats_checked  = 0;
	int reg_writes     = 0;
	int quiet_cycles   = 0;
	int act_seen [8];

	tap_hold_key_resolver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.mode          (mode),
		.key_class     (key_class),
		.key_index     (key_index),
		.pressed       (pressed),
		.now_ms        (now_ms),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.action        (action),
		.key_index_res (key_index_res),
		.pass_through  (pass_through),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void push_beat(input logic [2:0] act,
			input logic [thkr_pkg::IDX_W-1:0] k, input logic pt, input logic lst);
		res_beat_t b;
		b.action       = act;
		b.key_index    = k;
		b.pass_through = pt;
		b.last         = lst;
		pending_beats.push_back(b);
	endfunction

	task automatic reset_key_model();
		for (int i = 0; i < NMOD; i++) mod_start[i] = '0;
		for (int i = 0; i < NPREF; i++) pref_start[i] = '0;
		mod_down    = '0;
		mod_hold    = '0;
		pref_down   = '0;
		pref_hold   = '0;
		pref_tapped = '0;
		term        = thkr_pkg::TERM_RESET;
		hold_mask   = thkr_pkg::MASK_RESET;
	endtask

	// Work out the beats one accepted item causes and advance the key state
	task automatic resolve_key_item(input key_item_t it);
		logic [1:0]                  cls;
		logic [thkr_pkg::TIME_W-1:0] el;
		logic [thkr_pkg::IDX_W-1:0]  k;
		cls = it.key_class;
		k   = it.key_index;
		if (it.mode == MODE_SCAN) begin
			// Scan: promote keys held past the term, modifiers first
			for (int i = 0; i < NMOD; i++) begin
				el = it.now_ms - mod_start[i];
				if (mod_down[i] && !mod_hold[i] && el > term) begin
					push_beat(thkr_pkg::ACT_MOD_PRESS, 4'(i), 1'b0, 1'b0);
					mod_hold[i] = 1'b1;
				end
			end
			for (int i = 0; i < NPREF; i++) begin
				el = it.now_ms - pref_start[i];
				if (pref_down[i] && !pref_hold[i] && !pref_tapped[i] && el > term) begin
					push_beat(hold_mask[i] ? thkr_pkg::ACT_HOLD_PRESS
						: thkr_pkg::ACT_HOLD_TAP, 4'(i), 1'b0, 1'b0);
					pref_hold[i] = 1'b1;
				end
			end
			push_beat(thkr_pkg::ACT_END, '0, 1'b0, 1'b1);
		end else begin
			// Out-of-range grouped keys and the spare class act as other keys
			if ((cls == thkr_pkg::CLS_MOD && k >= NMOD) ||
					(cls == thkr_pkg::CLS_PREF && k >= NPREF) || cls == CLS_SPARE) begin
				cls = thkr_pkg::CLS_OTHER;
			end
			if (it.pressed) begin
				// Any other press turns pending tap-preferred keys into taps
				for (int i = 0; i < NPREF; i++) begin
					if (pref_down[i] && !pref_hold[i] && !pref_tapped[i] &&
							!(cls == thkr_pkg::CLS_PREF && k == i)) begin
						push_beat(thkr_pkg::ACT_TAP, 4'(i), 1'b0, 1'b0);
						pref_tapped[i] = 1'b1;
					end
				end
				// A non-modifier press turns pending modifiers into holds
				if (cls != thkr_pkg::CLS_MOD) begin
					for (int i = 0; i < NMOD; i++) begin
						if (mod_down[i] && !mod_hold[i]) begin
							push_beat(thkr_pkg::ACT_MOD_PRESS, 4'(i), 1'b0, 1'b0);
							mod_hold[i] = 1'b1;
						end
					end
				end
			end
			if (cls == thkr_pkg::CLS_MOD) begin
				if (it.pressed) begin
					mod_start[k] = it.now_ms;
					mod_down[k]  = 1'b1;
					mod_hold[k]  = 1'b0;
				end else begin
					push_beat(mod_hold[k] ? thkr_pkg::ACT_MOD_RELEASE : thkr_pkg::ACT_TAP,
						k, 1'b0, 1'b0);
					mod_down[k] = 1'b0;
					mod_hold[k] = 1'b0;
				end
			end else if (cls == thkr_pkg::CLS_PREF) begin
				if (it.pressed) begin
					pref_start[k]  = it.now_ms;
					pref_down[k]   = 1'b1;
					pref_hold[k]   = 1'b0;
					pref_tapped[k] = 1'b0;
				end else begin
					if (pref_hold[k]) begin
						if (hold_mask[k]) begin
							push_beat(thkr_pkg::ACT_HOLD_RELEASE, k, 1'b0, 1'b0);
						end
					end else if (!pref_tapped[k]) begin
						push_beat(thkr_pkg::ACT_TAP, k, 1'b0, 1'b0);
					end
					pref_down[k]   = 1'b0;
					pref_hold[k]   = 1'b0;
					pref_tapped[k] = 1'b0;
				end
			end
			push_beat(thkr_pkg::ACT_END, '0, cls == thkr_pkg::CLS_OTHER, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Offer one item; hold it until the block takes it, then predict.
	// Valid stays high afterwards so back-to-back items need no gap.
	task automatic send_item(input key_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < evt_idle_pct) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		mode      <= it.mode;
		key_class <= it.key_class;
		key_index <= it.key_index;
		pressed   <= it.pressed;
		now_ms    <= it.now_ms;
		do @(posedge clk); while (evt_stall);
		resolve_key_item(it);
		items_sent++;
	endtask

	// Drop valid and pause until every owed beat has come back
	task automatic drain_results();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	// Write a register with the block idle
	task automatic write_reg(input logic idx, input logic [thkr_pkg::CFG_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == thkr_pkg::CFG_TAPPING_TERM) term = data;
		else hold_mask = data[thkr_pkg::MASK_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: a counted hold-off stretch takes priority over random stalls
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			res_stall <= 1'b1;
			hold_off_left = hold_off_left - 1;
		end else begin
			res_stall <= ($urandom_range(99) < res_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker and watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		res_beat_t got;
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			got.action       = action;
			got.key_index    = key_index_res;
			got.pass_through = pass_through;
			got.last         = last;
			act_seen[action] = act_seen[action] + 1;
			beats_checked++;
			if (pending_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: action %0d key %0d pass %0b last %0b",
					$time, got.action, got.key_index, got.pass_through, got.last);
			end else begin
				want = pending_beats.pop_front();
				if (got.action !== want.action || got.key_index !== want.key_index ||
						got.pass_through !== want.pass_through ||
						got.last !== want.last) begin
					errors++;
					$display("%0t: result mismatch: expected action %0d key %0d %s",
						$time, want.action, want.key_index,
						$sformatf("pass %0b last %0b, got action %0d key %0d %s",
							want.pass_through, want.last, got.action, got.key_index,
							$sformatf("pass %0b last %0b",
								got.pass_through, got.last)));
				end
			end
		end
	end

	// Count cycles with no beat on any channel; a stuck block ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d beats still owed",
					$time, HANG_LIMIT, pending_beats.size());
				$display("tap_hold_key_resolver regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic key_item_t key_evt(input logic [1:0] cls,
			input logic [thkr_pkg::IDX_W-1:0] k, input logic pr,
			input logic [thkr_pkg::TIME_W-1:0] t);
		key_item_t it;
		it.mode      = MODE_KEY;
		it.key_class = cls;
		it.key_index = k;
		it.pressed   = pr;
		it.now_ms    = t;
		return it;
	endfunction

	function automatic key_item_t scan_evt(input logic [thkr_pkg::TIME_W-1:0] t);
		key_item_t it;
		it           = key_item_t'($urandom);
		it.mode      = MODE_SCAN;
		it.now_ms    = t;
		return it;
	endfunction

	// Build the next random item: mostly plausible typing against a running
	// millisecond clock, with scans mixed in and some raw noise
	task automatic next_random_item(output key_item_t it);
		int pick;
		int step;
		logic [thkr_pkg::IDX_W-1:0] k;
		step = $urandom_range(9);
		if (step < 6) ms_clock = ms_clock + 16'($urandom_range(0, 60));
		else if (step < 9) ms_clock = ms_clock + 16'($urandom_range(100, 400));
		else ms_clock = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			it = key_item_t'($urandom);
		end else if (pick < 40) begin
			it = scan_evt(ms_clock);
		end else if (pick < 50) begin
			it = key_evt(thkr_pkg::CLS_OTHER, 4'($urandom), 1'($urandom), ms_clock);
		end else if (pick < 72) begin
			// Toggle a modifier-tap key
			k  = 4'($urandom_range(NMOD - 1));
			it = key_evt(thkr_pkg::CLS_MOD, k, !mod_phys[k], ms_clock);
			mod_phys[k] = !mod_phys[k];
		end else begin
			// Toggle a tap-preferred key
			k  = 4'($urandom_range(NPREF - 1));
			it = key_evt(thkr_pkg::CLS_PREF, k, !pref_phys[k], ms_clock);
			pref_phys[k] = !pref_phys[k];
		end
	endtask

	task automatic run_traffic(input int n, input int idle_pct, input int stall_pct);
		key_item_t it;
		evt_idle_pct  = idle_pct;
		res_stall_pct = stall_pct;
		repeat (n) begin
			next_random_item(it);
			send_item(it);
		end
	endtask

	// Hand-picked sequences at the default register values
	task automatic test_directed();
		// Modifier becomes a hold through another key, tap-preferred key held to the term
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd0, 1'b1, 16'd0));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd5, 1'b1, 16'd10));
		send_item(scan_evt(16'd300));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd5, 1'b0, 16'd310));
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd0, 1'b0, 16'd320));
		// Quick modifier tap at the top of the timer range
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd6, 1'b1, 16'hFFFF));
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd6, 1'b0, 16'hFFFF));
		// Hold across the timer wrap, with the mask bit clear
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd0, 1'b1, 16'd65500));
		send_item(scan_evt(16'd100));
		send_item(scan_evt(16'd300));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd0, 1'b0, 16'd310));
		// Roll-over tap, then a repeated press
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd10, 1'b1, 16'd0));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd3, 1'b1, 16'd5));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd10, 1'b0, 16'd6));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd3, 1'b1, 16'd7));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd3, 1'b0, 16'd8));
		// Releases with no press before them
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd2, 1'b0, 16'd9));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd7, 1'b0, 16'd9));
		// Out-of-range indexes and the spare class fall through as other keys
		send_item(key_evt(thkr_pkg::CLS_MOD, 4'd15, 1'b1, 16'd11));
		send_item(key_evt(thkr_pkg::CLS_PREF, 4'd11, 1'b0, 16'd12));
		send_item(key_evt(CLS_SPARE, 4'd5, 1'b1, 16'd13));
		send_item(key_evt(thkr_pkg::CLS_OTHER, 4'd0, 1'b0, 16'd14));
		// Scan with every other field set to ones
		send_item(key_item_t'({MODE_SCAN, CLS_SPARE, 4'hF, 1'b1, 16'hFFFF}));
	endtask

	// Random typing under each idling mix
	task automatic test_idling_mixes();
		run_traffic(50, 0, 0);
		run_traffic(50, 47, 0);
		run_traffic(50, 0, 47);
		run_traffic(50, 28, 28);
	endtask

	// Sweep both registers through their extremes; keys may stay down across
	// a write, so a mask change while a key is held is exercised too
	task automatic test_register_sweep();
		write_reg(thkr_pkg::CFG_TAPPING_TERM, 16'd0);
		write_reg(thkr_pkg::CFG_HOLD_MASK, {5'($urandom), 11'd0});
		run_traffic(25, 28, 28);
		write_reg(thkr_pkg::CFG_TAPPING_TERM, 16'hFFFF);
		write_reg(thkr_pkg::CFG_HOLD_MASK, {5'($urandom), 11'h7FF});
		run_traffic(25, 28, 28);
		write_reg(thkr_pkg::CFG_TAPPING_TERM, 16'($urandom_range(1, 600)));
		write_reg(thkr_pkg::CFG_HOLD_MASK, 16'($urandom));
		run_traffic(25, 28, 28);
		write_reg(thkr_pkg::CFG_TAPPING_TERM, thkr_pkg::TERM_RESET);
		write_reg(thkr_pkg::CFG_HOLD_MASK, {5'd0, thkr_pkg::MASK_RESET});
		run_traffic(25, 0, 0);
	endtask

	// Hold off the receiver long enough that the block backs up into its
	// input, keep offering items, then pause the sender until all is back
	task automatic test_backpressure();
		key_item_t it;
		evt_idle_pct  = 0;
		res_stall_pct = 0;
		hold_off_left = 6 * ITEM_CYCLES;
		repeat (15) begin
			next_random_item(it);
			send_item(it);
		end
		drain_results();
		run_traffic(10, 0, 28);
	endtask

	initial begin
		reset_key_model();
		for (int i = 0; i < 8; i++) act_seen[i] = 0;
		// Hold reset low at the start, then release it on a falling edge, away from the rising edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_idling_mixes();
		test_register_sweep();
		test_backpressure();

		// Wait out every owed beat, then watch for stray ones
		drain_results();
		res_stall_pct = 0;
		repeat (3 * ITEM_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			errors++;
			$display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
		end

		$display("covered %0d items, %0d result beats, %0d register writes, mismatches %0d",
			items_sent, beats_checked, reg_writes, errors);
		$display("actions: tap %0d, hold tap %0d, hold press %0d, hold release %0d, %s",
			act_seen[thkr_pkg::ACT_TAP], act_seen[thkr_pkg::ACT_HOLD_TAP],
			act_seen[thkr_pkg::ACT_HOLD_PRESS], act_seen[thkr_pkg::ACT_HOLD_RELEASE],
			$sformatf("mod press %0d, mod release %0d, end %0d",
				act_seen[thkr_pkg::ACT_MOD_PRESS], act_seen[thkr_pkg::ACT_MOD_RELEASE],
				act_seen[thkr_pkg::ACT_END]));
		if (errors == 0) begin
			$display("tap_hold_key_resolver regression: pass");
		end else begin
			$display("tap_hold_key_resolver regression: fail");
		end
		$finish;
	end

endmodule
